/* hw/rtl/eam_pkg.sv */
// ----------------------------------------------------------------------------
// eam_pkg
// Types and constants shared by the environment alarm manager and its channels.
// ----------------------------------------------------------------------------
package eam_pkg;

    localparam logic [2:0] OP_CHECK      = 3'd0;
    localparam logic [2:0] OP_RAISE      = 3'd1;
    localparam logic [2:0] OP_CLEAR_KIND = 3'd2;
    localparam logic [2:0] OP_CLEAR_ALL  = 3'd3;
    localparam logic [2:0] OP_SNOOZE     = 3'd4;
    localparam logic [2:0] OP_DISMISS    = 3'd5;
    localparam logic [2:0] OP_READ       = 3'd6;

    localparam logic [3:0] KIND_NONE         = 4'd0;
    localparam logic [3:0] KIND_SENSOR_FAIL  = 4'd1;
    localparam logic [3:0] KIND_CO2_CRITICAL = 4'd2;
    localparam logic [3:0] KIND_CO2_HIGH     = 4'd3;
    localparam logic [3:0] KIND_TEMP_HIGH    = 4'd4;
    localparam logic [3:0] KIND_TEMP_LOW     = 4'd5;
    localparam logic [3:0] KIND_HUM_HIGH     = 4'd6;
    localparam logic [3:0] KIND_HUM_LOW      = 4'd7;
    localparam logic [3:0] KIND_TURNING      = 4'd8;
    localparam logic [3:0] KIND_MISMATCH     = 4'd11;

    localparam logic [3:0] CFG_TARGET_TEMP = 4'd0;
    localparam logic [3:0] CFG_TEMP_TOL    = 4'd1;
    localparam logic [3:0] CFG_HUM_LOW     = 4'd2;
    localparam logic [3:0] CFG_HUM_HIGH    = 4'd3;
    localparam logic [3:0] CFG_CO2_HIGH    = 4'd4;
    localparam logic [3:0] CFG_CO2_CRIT    = 4'd5;
    localparam logic [3:0] CFG_MUTE_MS     = 4'd6;
    localparam logic [3:0] CFG_COOLDOWN_MS = 4'd7;

    localparam logic signed [11:0] RST_TARGET_TEMP = 12'sd375;
    localparam logic [8:0]         RST_TEMP_TOL    = 9'd5;
    localparam logic [9:0]         RST_HUM_LOW     = 10'd500;
    localparam logic [9:0]         RST_HUM_HIGH    = 10'd650;
    localparam logic [15:0]        RST_CO2_HIGH    = 16'd0;
    localparam logic [15:0]        RST_CO2_CRIT    = 16'd0;
    localparam logic [31:0]        RST_MUTE_MS     = 32'd300000;
    localparam logic [31:0]        RST_COOLDOWN_MS = 32'd5000;

    localparam logic [31:0] DISMISS_MS     = 32'd86400000;
    localparam logic [4:0]  HIST_COUNT_MAX = 5'd31;

    typedef struct packed {
        logic [2:0]         operation;
        logic [31:0]        now_ms;
        logic signed [11:0] temperature;
        logic [9:0]         humidity;
        logic               sensor_ok;
        logic [15:0]        co2_ppm;
        logic [3:0]         alarm_kind;
        logic [31:0]        snooze_ms;
        logic [3:0]         history_slot;
    } in_item_t;

    typedef struct packed {
        logic        alarm_active;
        logic [3:0]  active_kind;
        logic        mute_in_force;
        logic        speaker_on;
        logic        alarm_raised;
        logic [4:0]  history_count;
        logic [3:0]  history_kind;
        logic [31:0] history_time;
    } out_item_t;

    typedef struct packed {
        logic [3:0]  index;
        logic [31:0] data;
    } cfg_req_t;

endpackage

/* hw/rtl/eam_channels.sv */
// ----------------------------------------------------------------------------
// eam_channels
// Valid/ready channels for items, results and configuration requests.
// ----------------------------------------------------------------------------
interface eam_in_if;
    logic               valid;
    logic               ready;
    eam_pkg::in_item_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface eam_out_if;
    logic               valid;
    logic               ready;
    eam_pkg::out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface eam_cfg_if;
    logic               valid;
    logic               ready;
    eam_pkg::cfg_req_t  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/environment_alarm_manager.sv */
// ----------------------------------------------------------------------------
// environment_alarm_manager
// Priority alarm manager with mute handling and a history ring.
// ----------------------------------------------------------------------------
// Channels: item takes one request per handshake (check, raise, clear, clear
// all, snooze, dismiss, history read); result returns one status item per
// request; cfg writes one limit register per handshake and is always ready.
// A request is held in the input register and its status in the result
// register. Throughput is one request per cycle: the input register
// and the result register each take a new entry whenever the next one frees.
// History reads use one registered read port of the ring memory, which fills
// the result register's history fields in the same cycle as the status.
// Reset clears the alarm, the mute, the ring pointers and both valid flags
// and loads the register defaults; the ring contents are not cleared, and
// slots beyond the fill count read as zero.
// When the receiver stalls, the result holds; one more request is taken into
// the input register and then item.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module environment_alarm_manager #(
    parameter int HISTORY_DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    eam_cfg_if.sink   cfg,
    eam_in_if.sink    item,
    eam_out_if.source result
);

    localparam int PTR_W  = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int CALC_W = ((CNT_W > 5) ? CNT_W : 5) + 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(HISTORY_DEPTH);

    logic signed [11:0] target_temp_reg;
    logic [8:0]         temp_tol_reg;
    logic [9:0]         hum_low_reg;
    logic [9:0]         hum_high_reg;
    logic [15:0]        co2_high_reg;
    logic [15:0]        co2_crit_reg;
    logic [31:0]        mute_ms_reg;
    logic [31:0]        cooldown_reg;

    logic               a_valid_reg;
    eam_pkg::in_item_t  a_item_reg;
    logic               out_valid_reg;

    logic [3:0]         kind_reg, kind_next;
    logic               active_reg, active_next;
    logic [31:0]        last_raise_reg, last_raise_next;
    logic               mute_reg, mute_next;
    logic [31:0]        deadline_reg, deadline_next;
    logic [PTR_W-1:0]   wpos_reg, wpos_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;

    logic               st_active_reg;
    logic [3:0]         st_kind_reg;
    logic               st_muted_reg;
    logic               st_raised_reg;
    logic [4:0]         st_count_reg;
    logic               hit_reg;
    logic [3:0]         hist_kind_reg;
    logic [31:0]        hist_time_reg;

    logic [3:0]         ring_kind_mem [HISTORY_DEPTH];
    logic [31:0]        ring_time_mem [HISTORY_DEPTH];

    logic               advance;
    logic               cooling;
    logic [3:0]         det_kind;
    logic [3:0]         raise_kind;
    logic               raise_en;
    logic               muted_now;
    logic               hit;
    logic [PTR_W-1:0]   rd_idx;
    logic [CALC_W-1:0]  back;
    logic [CALC_W-1:0]  wpos_ext;
    logic [CALC_W-1:0]  rd_diff;
    logic [CALC_W-1:0]  fill_ext;
    logic [4:0]         count_sat;
    logic signed [13:0] temp_ext;
    logic signed [13:0] temp_hi_lim;
    logic signed [13:0] temp_lo_lim;

    assign advance    = a_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !a_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        temp_ext    = 14'($signed(a_item_reg.temperature));
        temp_hi_lim = 14'(target_temp_reg) + $signed({5'b0, temp_tol_reg});
        temp_lo_lim = 14'(target_temp_reg) - $signed({5'b0, temp_tol_reg});
        cooling     = active_reg && ((a_item_reg.now_ms - last_raise_reg) < cooldown_reg);

        if (!a_item_reg.sensor_ok)
            det_kind = eam_pkg::KIND_SENSOR_FAIL;
        else if ((co2_crit_reg != 16'd0) && (a_item_reg.co2_ppm >= co2_crit_reg))
            det_kind = eam_pkg::KIND_CO2_CRITICAL;
        else if ((co2_high_reg != 16'd0) && (a_item_reg.co2_ppm >= co2_high_reg))
            det_kind = eam_pkg::KIND_CO2_HIGH;
        else if (temp_ext > temp_hi_lim)
            det_kind = eam_pkg::KIND_TEMP_HIGH;
        else if (temp_ext < temp_lo_lim)
            det_kind = eam_pkg::KIND_TEMP_LOW;
        else if (a_item_reg.humidity > hum_high_reg)
            det_kind = eam_pkg::KIND_HUM_HIGH;
        else if (a_item_reg.humidity < hum_low_reg)
            det_kind = eam_pkg::KIND_HUM_LOW;
        else
            det_kind = eam_pkg::KIND_NONE;
    end

    always_comb
    begin
        back     = CALC_W'(a_item_reg.history_slot) + CALC_W'(1);
        wpos_ext = CALC_W'(wpos_reg);
        if (wpos_ext >= back)
            rd_diff = wpos_ext - back;
        else
            rd_diff = wpos_ext + CALC_W'(HISTORY_DEPTH) - back;
        rd_idx = rd_diff[PTR_W-1:0];
        hit    = (a_item_reg.operation == eam_pkg::OP_READ)
              && (CALC_W'(a_item_reg.history_slot) < CALC_W'(fill_reg));
    end

    always_comb
    begin
        kind_next       = kind_reg;
        active_next     = active_reg;
        last_raise_next = last_raise_reg;
        mute_next       = mute_reg;
        deadline_next   = deadline_reg;
        raise_en        = 1'b0;
        raise_kind      = a_item_reg.alarm_kind;

        case (a_item_reg.operation)
            eam_pkg::OP_CHECK:
            begin
                if (!cooling)
                begin
                    if (det_kind != eam_pkg::KIND_NONE)
                    begin
                        raise_en   = 1'b1;
                        raise_kind = det_kind;
                    end
                    else if (active_reg && !(kind_reg inside
                             {[eam_pkg::KIND_TURNING:eam_pkg::KIND_MISMATCH]}))
                    begin
                        kind_next   = eam_pkg::KIND_NONE;
                        active_next = 1'b0;
                        mute_next   = 1'b0;
                    end
                end
            end
            eam_pkg::OP_RAISE:
            begin
                raise_en = a_item_reg.alarm_kind inside
                           {[eam_pkg::KIND_SENSOR_FAIL:eam_pkg::KIND_MISMATCH]};
            end
            eam_pkg::OP_CLEAR_KIND:
            begin
                if (kind_reg == a_item_reg.alarm_kind)
                begin
                    kind_next   = eam_pkg::KIND_NONE;
                    active_next = 1'b0;
                end
            end
            eam_pkg::OP_CLEAR_ALL:
            begin
                kind_next   = eam_pkg::KIND_NONE;
                active_next = 1'b0;
                mute_next   = 1'b0;
            end
            eam_pkg::OP_SNOOZE:
            begin
                if (active_reg)
                begin
                    mute_next     = 1'b1;
                    deadline_next = a_item_reg.now_ms + ((a_item_reg.snooze_ms == 32'd0)
                                    ? mute_ms_reg : a_item_reg.snooze_ms);
                end
            end
            eam_pkg::OP_DISMISS:
            begin
                if (active_reg)
                begin
                    kind_next     = eam_pkg::KIND_NONE;
                    active_next   = 1'b0;
                    mute_next     = 1'b1;
                    deadline_next = a_item_reg.now_ms + eam_pkg::DISMISS_MS;
                end
            end
            default:
            begin
            end
        endcase

        wpos_next = wpos_reg;
        fill_next = fill_reg;
        if (raise_en)
        begin
            kind_next       = raise_kind;
            active_next     = 1'b1;
            last_raise_next = a_item_reg.now_ms;
            wpos_next       = (wpos_reg == PTR_LAST) ? '0 : wpos_reg + PTR_W'(1);
            if (fill_reg < FILL_MAX)
                fill_next = fill_reg + CNT_W'(1);
            if (kind_reg != raise_kind)
                mute_next = 1'b0;
        end

        muted_now = mute_next && (a_item_reg.now_ms < deadline_next);
        fill_ext  = CALC_W'(fill_next);
        count_sat = (fill_ext > CALC_W'(eam_pkg::HIST_COUNT_MAX))
                  ? eam_pkg::HIST_COUNT_MAX : fill_ext[4:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_temp_reg <= eam_pkg::RST_TARGET_TEMP;
            temp_tol_reg    <= eam_pkg::RST_TEMP_TOL;
            hum_low_reg     <= eam_pkg::RST_HUM_LOW;
            hum_high_reg    <= eam_pkg::RST_HUM_HIGH;
            co2_high_reg    <= eam_pkg::RST_CO2_HIGH;
            co2_crit_reg    <= eam_pkg::RST_CO2_CRIT;
            mute_ms_reg     <= eam_pkg::RST_MUTE_MS;
            cooldown_reg    <= eam_pkg::RST_COOLDOWN_MS;
        end
        else if (cfg.valid)
        begin
            case (cfg.payload.index)
                eam_pkg::CFG_TARGET_TEMP: target_temp_reg <= $signed(cfg.payload.data[11:0]);
                eam_pkg::CFG_TEMP_TOL:    temp_tol_reg    <= cfg.payload.data[8:0];
                eam_pkg::CFG_HUM_LOW:     hum_low_reg     <= cfg.payload.data[9:0];
                eam_pkg::CFG_HUM_HIGH:    hum_high_reg    <= cfg.payload.data[9:0];
                eam_pkg::CFG_CO2_HIGH:    co2_high_reg    <= cfg.payload.data[15:0];
                eam_pkg::CFG_CO2_CRIT:    co2_crit_reg    <= cfg.payload.data[15:0];
                eam_pkg::CFG_MUTE_MS:     mute_ms_reg     <= cfg.payload.data;
                eam_pkg::CFG_COOLDOWN_MS: cooldown_reg    <= cfg.payload.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= eam_pkg::KIND_NONE;
            active_reg     <= 1'b0;
            last_raise_reg <= '0;
            mute_reg       <= 1'b0;
            deadline_reg   <= '0;
            wpos_reg       <= '0;
            fill_reg       <= '0;
        end
        else
        begin
            if (item.valid && item.ready)
                a_valid_reg <= 1'b1;
            else if (advance)
                a_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                kind_reg       <= kind_next;
                active_reg     <= active_next;
                last_raise_reg <= last_raise_next;
                mute_reg       <= mute_next;
                deadline_reg   <= deadline_next;
                wpos_reg       <= wpos_next;
                fill_reg       <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            a_item_reg <= item.payload;
        if (advance)
        begin
            st_active_reg <= active_next;
            st_kind_reg   <= kind_next;
            st_muted_reg  <= muted_now;
            st_raised_reg <= raise_en;
            st_count_reg  <= count_sat;
            hit_reg       <= hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && raise_en)
        begin
            ring_kind_mem[wpos_reg] <= raise_kind;
            ring_time_mem[wpos_reg] <= a_item_reg.now_ms;
        end
        if (advance)
        begin
            hist_kind_reg <= ring_kind_mem[rd_idx];
            hist_time_reg <= ring_time_mem[rd_idx];
        end
    end

    always_comb
    begin
        result.valid                 = out_valid_reg;
        result.payload.alarm_active  = st_active_reg;
        result.payload.active_kind   = st_kind_reg;
        result.payload.mute_in_force = st_muted_reg;
        result.payload.speaker_on    = st_active_reg && !st_muted_reg;
        result.payload.alarm_raised  = st_raised_reg;
        result.payload.history_count = st_count_reg;
        result.payload.history_kind  = hit_reg ? hist_kind_reg : eam_pkg::KIND_NONE;
        result.payload.history_time  = hit_reg ? hist_time_reg : 32'd0;
    end

endmodule

/* hw/rtl/eam_checker.sv */
// ----------------------------------------------------------------------------
// eam_port_checks
// Port-level checks on the alarm manager's request and result channels.
// ----------------------------------------------------------------------------
module eam_port_checks (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input eam_pkg::out_item_t out_payload
);

    logic [4:0] last_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_count_reg <= 5'd0;
        else if (out_valid && out_ready)
            last_count_reg <= out_payload.history_count;
    end

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result changed while stalled");

    a_stall_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("request stalled without a stalled result");

    a_raise_records: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.alarm_raised |->
            out_payload.alarm_active && (out_payload.history_count != 5'd0))
        else $error("raised alarm not active or not recorded");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_payload.history_count >= last_count_reg)
        else $error("history count decreased");

endmodule

bind environment_alarm_manager eam_port_checks u_eam_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (item.valid),
    .in_ready    (item.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_payload (result.payload)
);
